// File: hdl/cfgtok_pkg.sv
// Shared types, codes and character constants for the configuration text tokenizer.
package cfgtok_pkg;

	localparam int POSITION_WIDTH = 16;
	localparam int NUMBER_WIDTH   = 32;

	localparam int POS_OUT_W = 16;
	localparam int NUM_OUT_W = 32;
	localparam int LEN_W     = 16;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	// event codes
	localparam logic [1:0] EV_TEXT  = 2'd0;
	localparam logic [1:0] EV_TOKEN = 2'd1;
	localparam logic [1:0] EV_ERROR = 2'd2;

	// token kinds
	localparam logic [2:0] K_EOF     = 3'd0;
	localparam logic [2:0] K_LBRACE  = 3'd1;
	localparam logic [2:0] K_RBRACE  = 3'd2;
	localparam logic [2:0] K_EQUAL   = 3'd3;
	localparam logic [2:0] K_STRING  = 3'd4;
	localparam logic [2:0] K_NUMERAL = 3'd5;
	localparam logic [2:0] K_IDENT   = 3'd6;

	// error codes
	localparam logic [1:0] ERR_SYMBOL      = 2'd0;
	localparam logic [1:0] ERR_UNPRINTABLE = 2'd1;
	localparam logic [1:0] ERR_ESCAPE      = 2'd2;

	// character constants
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LN     = 8'h6E;
	localparam logic [7:0] CH_LR     = 8'h72;
	localparam logic [7:0] CH_LT     = 8'h74;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	// one result transaction
	typedef struct packed {
		logic [1:0]           ev;
		logic [2:0]           kind;
		logic [7:0]           ch;
		logic [NUM_OUT_W-1:0] num;
		logic [POS_OUT_W-1:0] line;
		logic [POS_OUT_W-1:0] col;
		logic [LEN_W-1:0]     len;
		logic [1:0]           err;
		logic                 last;
	} res_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
	endfunction

	// translate the byte after a backslash; zero means invalid escape
	function automatic logic [7:0] esc_xlate(input logic [7:0] c);
		logic [7:0] t;
		case (c)
			CH_LN:     t = CH_LF;
			CH_LT:     t = CH_TAB;
			CH_LR:     t = CH_CR;
			CH_BSLASH: t = CH_BSLASH;
			default:   t = CH_NUL;
		endcase
		return t;
	endfunction

endpackage

// File: hdl/config_text_tokenizer_core.sv
// Character-stream tokenizer: input register, decode logic and a two-entry result queue.
// Flow: a character accepted into the input register is decoded combinationally and written
//   to the result queue when it fires; its results are then taken from the queue.
// Throughput: one character per cycle while each character yields at most one result and
//   res_stall is low; a character that closes a token and starts the next yields two results.
// Reset: arst_n clears mode, positions, counters, the input valid flag and the result queue control.
module config_text_tokenizer_core
	import cfgtok_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  logic [7:0]           character,
	input  logic                 end_of_input,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [1:0]           event_res,
	output logic [2:0]           token_kind,
	output logic [7:0]           text_char,
	output logic [NUM_OUT_W-1:0] number_value,
	output logic [POS_OUT_W-1:0] token_line,
	output logic [POS_OUT_W-1:0] token_column,
	output logic [LEN_W-1:0]     token_length,
	output logic [1:0]           error_code,
	output logic                 last
);

	localparam logic [2:0] M_BETWEEN = 3'd0;
	localparam logic [2:0] M_COMMENT = 3'd1;
	localparam logic [2:0] M_STRING  = 3'd2;
	localparam logic [2:0] M_ESCAPE  = 3'd3;
	localparam logic [2:0] M_NUMERAL = 3'd4;
	localparam logic [2:0] M_IDENT   = 3'd5;
	localparam logic [2:0] M_DROP    = 3'd6;

	localparam int ACC_W = NUMBER_WIDTH + 4;

	// input register
	logic       s1_valid;
	logic [7:0] char_s1;
	logic       eoi_s1;

	// tokenizer state
	logic [2:0]                mode_q;
	logic [POSITION_WIDTH-1:0] line_q, col_q, sline_q, scol_q;
	logic [LEN_W-1:0]          len_q;
	logic [NUMBER_WIDTH-1:0]   acc_q;

	logic [2:0]                mode_d;
	logic [POSITION_WIDTH-1:0] line_d, col_d, sline_d, scol_d;
	logic [LEN_W-1:0]          len_d;
	logic [NUMBER_WIDTH-1:0]   acc_d;

	// result queue
	res_t       ent_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;

	logic       pop, fire, end_cond;
	logic [1:0] free, n_res;
	res_t       r0, r1;

	// token-start helper outputs
	logic                    b_valid, b_start;
	res_t                    b_res;
	logic [2:0]              b_mode;
	logic [LEN_W-1:0]        b_len;
	logic [NUMBER_WIDTH-1:0] b_acc;

	logic [LEN_W-1:0] len_inc;
	logic [ACC_W-1:0] acc_wide;
	logic [7:0]       esc_ch;
	logic             c_blank, c_printable;

	// handshake
	assign pop        = (cnt_q != 2'd0) && !res_stall;
	assign free       = 2'd2 - cnt_q + {1'b0, pop};
	assign fire       = s1_valid && (n_res <= free);
	assign char_stall = s1_valid && !fire;
	assign res_valid  = cnt_q != 2'd0;

	// hold the accepted character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!char_stall) begin
			s1_valid <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= character;
			eoi_s1  <= end_of_input;
		end
	end

	assign end_cond    = eoi_s1 ||
		((char_s1 == CH_NUL) && (mode_q != M_STRING) && (mode_q != M_ESCAPE));
	assign c_blank     = (char_s1 == CH_SPACE) || (char_s1 == CH_TAB) || (char_s1 == CH_LF);
	assign c_printable = (char_s1 >= CH_SPACE) && (char_s1 <= CH_TILDE);
	assign len_inc     = (len_q == LEN_MAX) ? len_q : len_q + 1'b1;
	assign esc_ch      = esc_xlate(char_s1);

	// accumulate a digit: acc*10 + d, saturating
	assign acc_wide = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) +
		ACC_W'(char_s1 - CH_0);

	// classify a character seen between tokens
	always_comb begin
		b_valid        = 1'b0;
		b_start        = 1'b0;
		b_mode         = M_BETWEEN;
		b_len          = '0;
		b_acc          = '0;
		b_res          = '0;
		b_res.line     = POS_OUT_W'(line_q);
		b_res.col      = POS_OUT_W'(col_q);
		if (c_blank) begin
			b_mode = M_BETWEEN;
		end else if (char_s1 == CH_HASH) begin
			b_mode = M_COMMENT;
		end else if ((char_s1 == CH_LBRACE) || (char_s1 == CH_RBRACE) ||
				(char_s1 == CH_EQUAL)) begin
			b_valid    = 1'b1;
			b_res.ev   = EV_TOKEN;
			b_res.kind = (char_s1 == CH_LBRACE) ? K_LBRACE :
				((char_s1 == CH_RBRACE) ? K_RBRACE : K_EQUAL);
			b_res.ch   = char_s1;
			b_res.len  = LEN_W'(1);
		end else if (char_s1 == CH_QUOTE) begin
			b_mode  = M_STRING;
			b_start = 1'b1;
		end else if (is_digit(char_s1)) begin
			b_mode     = M_NUMERAL;
			b_start    = 1'b1;
			b_len      = LEN_W'(1);
			b_acc      = NUMBER_WIDTH'(char_s1 - CH_0);
			b_valid    = 1'b1;
			b_res.ev   = EV_TEXT;
			b_res.kind = K_NUMERAL;
			b_res.ch   = char_s1;
			b_res.len  = LEN_W'(1);
		end else if (is_alpha(char_s1) || (char_s1 == CH_UNDER)) begin
			b_mode     = M_IDENT;
			b_start    = 1'b1;
			b_len      = LEN_W'(1);
			b_valid    = 1'b1;
			b_res.ev   = EV_TEXT;
			b_res.kind = K_IDENT;
			b_res.ch   = char_s1;
			b_res.len  = LEN_W'(1);
		end else begin
			b_mode     = M_DROP;
			b_valid    = 1'b1;
			b_res.ev   = EV_ERROR;
			b_res.err  = ERR_SYMBOL;
		end
	end

	// decode one character against the current mode
	always_comb begin
		res_t txt, err_r, eof_r, cls;

		mode_d  = mode_q;
		line_d  = line_q;
		col_d   = col_q;
		sline_d = sline_q;
		scol_d  = scol_q;
		len_d   = len_q;
		acc_d   = acc_q;
		r0      = '0;
		r1      = '0;
		n_res   = 2'd0;

		txt      = '0;
		txt.ev   = EV_TEXT;
		txt.line = POS_OUT_W'(sline_q);
		txt.col  = POS_OUT_W'(scol_q);
		txt.len  = len_inc;
		txt.ch   = char_s1;

		err_r      = '0;
		err_r.ev   = EV_ERROR;
		err_r.line = POS_OUT_W'(line_q);
		err_r.col  = POS_OUT_W'(col_q);

		eof_r      = '0;
		eof_r.ev   = EV_TOKEN;
		eof_r.kind = K_EOF;
		eof_r.line = POS_OUT_W'(line_q);
		eof_r.col  = POS_OUT_W'(col_q);

		cls      = '0;
		cls.ev   = EV_TOKEN;
		cls.kind = (mode_q == M_NUMERAL) ? K_NUMERAL : K_IDENT;
		cls.num  = (mode_q == M_NUMERAL) ? NUM_OUT_W'(acc_q) : '0;
		cls.line = POS_OUT_W'(sline_q);
		cls.col  = POS_OUT_W'(scol_q);
		cls.len  = len_q;

		if (end_cond) begin
			unique case (mode_q)
				M_DROP: begin
					n_res = 2'd0;
				end
				M_STRING: begin
					r0     = err_r;
					r0.err = ERR_UNPRINTABLE;
					n_res  = 2'd1;
				end
				M_ESCAPE: begin
					r0     = err_r;
					r0.err = ERR_ESCAPE;
					n_res  = 2'd1;
				end
				M_NUMERAL, M_IDENT: begin
					r0    = cls;
					r1    = eof_r;
					n_res = 2'd2;
				end
				default: begin
					r0    = eof_r;
					n_res = 2'd1;
				end
			endcase
			// start over for a new text
			mode_d  = M_BETWEEN;
			line_d  = '0;
			col_d   = '0;
			sline_d = '0;
			scol_d  = '0;
			len_d   = '0;
			acc_d   = '0;
		end else begin
			unique case (mode_q)
				M_COMMENT: begin
					if (char_s1 == CH_LF) begin
						mode_d = M_BETWEEN;
					end
				end
				M_STRING: begin
					if (char_s1 == CH_QUOTE) begin
						r0      = '0;
						r0.ev   = EV_TOKEN;
						r0.kind = K_STRING;
						r0.line = POS_OUT_W'(sline_q);
						r0.col  = POS_OUT_W'(scol_q);
						r0.len  = len_q;
						n_res   = 2'd1;
						mode_d  = M_BETWEEN;
					end else if (char_s1 == CH_BSLASH) begin
						mode_d = M_ESCAPE;
					end else if (c_printable) begin
						len_d    = len_inc;
						r0       = txt;
						r0.kind  = K_STRING;
						n_res    = 2'd1;
					end else begin
						r0     = err_r;
						r0.err = ERR_UNPRINTABLE;
						n_res  = 2'd1;
						mode_d = M_DROP;
					end
				end
				M_ESCAPE: begin
					if (esc_ch != CH_NUL) begin
						len_d   = len_inc;
						r0      = txt;
						r0.kind = K_STRING;
						r0.ch   = esc_ch;
						n_res   = 2'd1;
						mode_d  = M_STRING;
					end else begin
						r0     = err_r;
						r0.err = ERR_ESCAPE;
						n_res  = 2'd1;
						mode_d = M_DROP;
					end
				end
				M_NUMERAL, M_IDENT: begin
					if ((mode_q == M_NUMERAL) ? is_digit(char_s1) :
							(is_alpha(char_s1) || is_digit(char_s1) ||
							(char_s1 == CH_UNDER) || (char_s1 == CH_DOT))) begin
						len_d   = len_inc;
						r0      = txt;
						r0.kind = (mode_q == M_NUMERAL) ? K_NUMERAL : K_IDENT;
						n_res   = 2'd1;
						if (mode_q == M_NUMERAL) begin
							acc_d = (acc_wide[ACC_W-1 -: 4] != 4'd0) ? '1 :
								acc_wide[NUMBER_WIDTH-1:0];
						end
					end else begin
						// close the token, then treat the byte as between tokens
						r0     = cls;
						r1     = b_res;
						n_res  = b_valid ? 2'd2 : 2'd1;
						mode_d = b_mode;
						if (b_start) begin
							sline_d = line_q;
							scol_d  = col_q;
							len_d   = b_len;
							acc_d   = b_acc;
						end
					end
				end
				M_DROP: begin
					n_res = 2'd0;
				end
				default: begin
					r0     = b_res;
					n_res  = b_valid ? 2'd1 : 2'd0;
					mode_d = b_mode;
					if (b_start) begin
						sline_d = line_q;
						scol_d  = col_q;
						len_d   = b_len;
						acc_d   = b_acc;
					end
				end
			endcase
			// advance position, saturating
			if (char_s1 == CH_LF) begin
				if (line_q != '1) begin
					line_d = line_q + 1'b1;
				end
				col_d = '0;
			end else if (col_q != '1) begin
				col_d = col_q + 1'b1;
			end
		end

		r0.last = (n_res == 2'd1);
		r1.last = 1'b1;
	end

	// advance tokenizer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_BETWEEN;
			line_q  <= '0;
			col_q   <= '0;
			sline_q <= '0;
			scol_q  <= '0;
			len_q   <= '0;
			acc_q   <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			line_q  <= line_d;
			col_q   <= col_d;
			sline_q <= sline_d;
			scol_q  <= scol_d;
			len_q   <= len_d;
			acc_q   <= acc_d;
		end
	end

	// result queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (fire && (n_res == 2'd1)) begin
				wr_q <= ~wr_q;
			end
			cnt_q <= cnt_q + (fire ? n_res : 2'd0) - {1'b0, pop};
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (fire && (n_res != 2'd0)) begin
			ent_q[wr_q] <= r0;
		end
		if (fire && (n_res == 2'd2)) begin
			ent_q[~wr_q] <= r1;
		end
	end

	assign event_res    = ent_q[rd_q].ev;
	assign token_kind   = ent_q[rd_q].kind;
	assign text_char    = ent_q[rd_q].ch;
	assign number_value = ent_q[rd_q].num;
	assign token_line   = ent_q[rd_q].line;
	assign token_column = ent_q[rd_q].col;
	assign token_length = ent_q[rd_q].len;
	assign error_code   = ent_q[rd_q].err;
	assign last         = ent_q[rd_q].last;

	// queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("result queue overflow");

	// occupancy follows pushes and pops
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == $past(cnt_q) + ($past(fire) ? $past(n_res) : 2'd0)
			- {1'b0, $past(pop)})
		else $error("result queue count mismatch");

	// an error mid-text leaves the tokenizer dropping input
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && !end_cond && (n_res == 2'd1) && (r0.ev == EV_ERROR) |=> mode_q == M_DROP)
		else $error("error did not enter drop mode");

	// end of input restarts positions
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_cond |=> (line_q == '0) && (col_q == '0) && (mode_q == M_BETWEEN))
		else $error("end of input did not restart state");

	// text transactions always carry a nonzero length
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (event_res == EV_TEXT) |-> token_length != '0)
		else $error("text transaction with zero length");

endmodule
